[sv/sfr_pkg.sv]
package sfr_pkg;

    // Default window depth and the bound on replacement bytes.
    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX     = 8;
    localparam int RCAP            = (REPLACE_MAX < 8) ? REPLACE_MAX : 8;

    // Most results one word can cause, not counting the end marker.
    localparam int BURST_MAX = 8;
    localparam int BIDX_W    = $clog2(BURST_MAX);
    localparam int CNT_W     = 4;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_PATTERN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_TEXT   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_LENGTH = 2'd3;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // One group of results handed from the window to the output stage.
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          nbytes;
        logic                      is_end;
        logic [15:0]               count;
    } burst_t;

endpackage

[sv/sfr_if.sv]
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] text_byte;

    modport source (output valid, input ready, output cmd, output text_byte);
    modport sink   (input valid, output ready, input cmd, input text_byte);
endinterface

interface sfr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        end_marker;
    logic [15:0] replace_count;

    modport source (output valid, input ready, output out_byte, output end_marker,
                    output replace_count);
    modport sink   (input valid, output ready, input out_byte, input end_marker,
                    input replace_count);
endinterface

[sv/sfr_window.sv]
module sfr_window
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   accept,
    input  logic                   cmd,
    input  logic [7:0]             text_byte,
    output burst_t                 burst
);

    localparam int PCAP = (PATTERN_MAX < 8) ? PATTERN_MAX : 8;

    logic [63:0]      pattern_reg;
    logic [3:0]       slen_reg;
    logic [63:0]      rtext_reg;
    logic [3:0]       rlen_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [15:0]      tally_reg, tally_next;
    logic [7:0]       win_reg  [PATTERN_MAX];
    logic [7:0]       win_next [PATTERN_MAX];
    logic [7:0]       win_new  [PATTERN_MAX];

    logic [3:0] slen_nz;
    logic [3:0] eff_len;
    logic [3:0] eff_rlen;
    logic       full;
    logic       same;

    assign slen_nz  = (slen_reg == 4'd0) ? 4'd1 : slen_reg;
    assign eff_len  = (slen_nz > 4'(PCAP)) ? 4'(PCAP) : slen_nz;
    assign eff_rlen = (rlen_reg > 4'(RCAP)) ? 4'(RCAP) : rlen_reg;
    assign full     = (fill_reg + 4'd1) == eff_len;

    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            win_new[k] = (fill_reg == 4'(k)) ? text_byte : win_reg[k];
        end
        same = 1'b1;
        for (int k = 0; k < PCAP; k++)
        begin
            if ((4'(k) < eff_len) && (win_new[k] != pattern_reg[8*k +: 8]))
            begin
                same = 1'b0;
            end
        end
    end

    always_comb
    begin
        win_next     = win_reg;
        fill_next    = fill_reg;
        tally_next   = tally_reg;
        burst.bytes  = '0;
        burst.nbytes = '0;
        burst.is_end = 1'b0;
        burst.count  = '0;
        if (accept)
        begin
            if (cmd == CMD_END)
            begin
                for (int k = 0; k < PCAP; k++)
                begin
                    burst.bytes[k] = win_reg[k];
                end
                burst.nbytes = fill_reg;
                burst.is_end = 1'b1;
                burst.count  = tally_reg;
                fill_next    = '0;
                tally_next   = '0;
            end
            else if (!full)
            begin
                win_next  = win_new;
                fill_next = fill_reg + 4'd1;
            end
            else if (same)
            begin
                burst.bytes  = rtext_reg;
                burst.nbytes = eff_rlen;
                fill_next    = '0;
                if (tally_reg != 16'hFFFF)
                begin
                    tally_next = tally_reg + 16'd1;
                end
            end
            else
            begin
                // Oldest byte leaves; the fill count stays at length minus one.
                burst.bytes[0] = win_new[0];
                burst.nbytes   = 4'd1;
                for (int k = 0; k < PATTERN_MAX - 1; k++)
                begin
                    win_next[k] = win_new[k + 1];
                end
                win_next[PATTERN_MAX-1] = win_new[PATTERN_MAX-1];
            end
        end
        if (cfg_wr_en && (cfg_index == CFG_SEARCH_LENGTH))
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            slen_reg    <= 4'd1;
            rtext_reg   <= '0;
            rlen_reg    <= '0;
            fill_reg    <= '0;
            tally_reg   <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            tally_reg <= tally_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SEARCH_PATTERN: pattern_reg <= cfg_data;
                    CFG_SEARCH_LENGTH:  slen_reg    <= cfg_data[3:0];
                    CFG_REPLACE_TEXT:   rtext_reg   <= cfg_data;
                    CFG_REPLACE_LENGTH: rlen_reg    <= cfg_data[3:0];
                    default:            pattern_reg <= pattern_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

[sv/sfr_burst.sv]
module sfr_burst
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  burst_t      burst,
    output logic        can_load,
    output logic        valid,
    input  logic        ready,
    output logic [7:0]  out_byte,
    output logic        end_marker,
    output logic [15:0] replace_count
);

    logic             active_reg, active_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    burst_t           held_reg;

    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] load_total;
    logic             last;
    logic             is_text;

    assign total      = held_reg.nbytes + CNT_W'(held_reg.is_end);
    assign load_total = burst.nbytes + CNT_W'(burst.is_end);
    assign last       = (idx_reg + 4'd1) == total;
    assign can_load   = !active_reg || (last && ready);

    assign is_text       = idx_reg < held_reg.nbytes;
    assign valid         = active_reg;
    assign out_byte      = is_text ? held_reg.bytes[idx_reg[BIDX_W-1:0]] : 8'd0;
    assign end_marker    = !is_text;
    assign replace_count = is_text ? 16'd0 : held_reg.count;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (active_reg && ready)
        begin
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
        if (load)
        begin
            active_next = load_total != '0;
            idx_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= burst;
        end
    end

endmodule

[sv/stream_find_and_replace.sv]
// Streaming find-and-replace: text arrives one byte per word on feed, and every
// leftmost, non-overlapping occurrence of the search pattern (1 to 8 bytes) leaves
// on result as the replacement text (0 to 8 bytes); other bytes pass unchanged, held
// back in the window until a full search length of bytes has arrived. An end word
// flushes the held bytes and then gives one end marker that carries the number of
// replacements, saturating at 65535, after which the count starts again at zero.
// Plain text streams at one byte per clock while result is ready. All results leave
// through one output register, one word per cycle while result is ready; a group of
// several words (a longer replacement, or held bytes and the end marker) holds
// feed until its last word is taken; that register lets feed take the next word in
// the cycle in which the last word of a group is taken. Configuration is written
// while the stream is idle; the user must keep to this, as the block does not
// enforce it. Writing the search length drops any held bytes.
module stream_find_and_replace
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sfr_in_if.sink                 feed,
    sfr_out_if.source              result
);

    burst_t burst;
    logic   accept;
    logic   can_load;

    assign feed.ready = can_load;
    assign accept     = feed.valid && can_load;

    sfr_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cmd       (feed.cmd),
        .text_byte (feed.text_byte),
        .burst     (burst)
    );

    sfr_burst u_burst (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .burst         (burst),
        .can_load      (can_load),
        .valid         (result.valid),
        .ready         (result.ready),
        .out_byte      (result.out_byte),
        .end_marker    (result.end_marker),
        .replace_count (result.replace_count)
    );

endmodule

[sv/sfr_checker.sv]
module sfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        feed_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [7:0]  res_byte,
    input logic        res_end,
    input logic [15:0] res_count
);

    // A stalled result word blocks feed: nothing new may enter behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !feed_ready)
        else $error("feed ready while a result word is stalled");

    // The end marker carries no text byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_end |-> res_byte == 8'd0)
        else $error("end marker with nonzero byte");

    // Text words carry no count.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_end |-> res_count == 16'd0)
        else $error("text word with nonzero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_end)
            && $stable(res_count))
        else $error("stalled result word changed");

endmodule

bind stream_find_and_replace sfr_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .feed_ready (feed.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_byte   (result.out_byte),
    .res_end    (result.end_marker),
    .res_count  (result.replace_count)
);

[test/stream_find_and_replace_tb.sv]
module stream_find_and_replace_tb;
    import sfr_pkg::*;

    localparam int WINDOW_CAP = (PATTERN_MAX_DEF < 8) ? PATTERN_MAX_DEF : 8;

    typedef struct packed {
        logic       cmd;
        logic [7:0] text_byte;
    } text_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        end_marker;
        logic [15:0] replace_count;
    } out_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sfr_in_if  feed_if ();
    sfr_out_if result_if ();

    stream_find_and_replace u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .feed      (feed_if),
        .result    (result_if)
    );

    text_word_t text_q[$];
    out_word_t  rewritten_q[$];
    int         mismatches;
    int         queued_words;

    // Shadow copy of the configuration and of the match window.
    logic [63:0] cfg_pattern;
    logic [63:0] cfg_rtext;
    logic [3:0]  cfg_slen;
    logic [3:0]  cfg_rlen;
    logic [7:0]  win [WINDOW_CAP];
    int          win_fill;
    logic [15:0] tally;
    logic [7:0]  alphabet [3];

    always #5 clk = ~clk;

    function automatic int search_span();
        int n;
        n = cfg_slen;
        if (n == 0)
            n = 1;
        if (n > WINDOW_CAP)
            n = WINDOW_CAP;
        return n;
    endfunction

    function automatic void rewrite_word(input logic cmd, input logic [7:0] b);
        int  slen;
        int  rlen;
        int  k;
        logic hit;
        slen = search_span();
        rlen = (cfg_rlen > RCAP) ? RCAP : cfg_rlen;
        if (win_fill > slen)
            win_fill = slen;
        if (cmd == CMD_END)
        begin
            for (k = 0; k < win_fill; k++)
                rewritten_q.push_back('{win[k], 1'b0, 16'd0});
            rewritten_q.push_back('{8'h00, 1'b1, tally});
            win_fill = 0;
            tally    = '0;
            return;
        end
        if (win_fill < WINDOW_CAP)
        begin
            win[win_fill] = b;
            win_fill++;
        end
        if (win_fill < slen)
            return;
        hit = 1'b1;
        for (k = 0; k < slen; k++)
            if (win[k] != cfg_pattern[8*k +: 8])
                hit = 1'b0;
        if (hit)
        begin
            for (k = 0; k < rlen; k++)
                rewritten_q.push_back('{cfg_rtext[8*k +: 8], 1'b0, 16'd0});
            win_fill = 0;
            if (tally != 16'hFFFF)
                tally++;
        end
        else
        begin
            rewritten_q.push_back('{win[0], 1'b0, 16'd0});
            for (k = 1; k < win_fill; k++)
                win[k-1] = win[k];
            win_fill--;
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int feed_burst = 0;
    int feed_gap   = 0;

    always @(posedge clk)
    begin : feed_driver
        text_word_t word;
        if (!rst_n)
        begin
            feed_if.valid <= 1'b0;
        end
        else if (!feed_if.valid || feed_if.ready)
        begin
            if (feed_gap > 0 || text_q.size() == 0)
            begin
                feed_if.valid <= 1'b0;
                if (feed_gap > 0)
                    feed_gap--;
            end
            else
            begin
                word = text_q.pop_front();
                feed_if.valid     <= 1'b1;
                feed_if.cmd       <= word.cmd;
                feed_if.text_byte <= word.text_byte;
                if (feed_burst > 0)
                    feed_burst--;
                if (feed_burst == 0)
                begin
                    feed_burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
                    feed_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
                end
            end
        end
    end

    // Receiver: its own stall pattern, switching among four stall modes at random.
    int       stall_mode = 0;
    int       stall_left = 0;
    bit [1:0] stall_phase = '0;

    always @(posedge clk)
    begin : result_sink
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 64);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= 1'($urandom_range(0, 1));
                2:       result_if.ready <= (stall_phase == 2'd0);
                default: result_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
            stall_phase++;
        end
    end

    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n)
        begin
            if (feed_if.valid && feed_if.ready)
                rewrite_word(feed_if.cmd, feed_if.text_byte);
            if (result_if.valid && result_if.ready)
            begin
                if (rewritten_q.size() == 0)
                begin
                    $error("unexpected word: out_byte %02h end_marker %0b replace_count %0d",
                           result_if.out_byte, result_if.end_marker, result_if.replace_count);
                    mismatches++;
                end
                else
                begin
                    want = rewritten_q.pop_front();
                    if (result_if.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, result_if.out_byte);
                        mismatches++;
                    end
                    if (result_if.end_marker !== want.end_marker)
                    begin
                        $error("end_marker: expected %0b, got %0b",
                               want.end_marker, result_if.end_marker);
                        mismatches++;
                    end
                    if (result_if.replace_count !== want.replace_count)
                    begin
                        $error("replace_count: expected %0d, got %0d",
                               want.replace_count, result_if.replace_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic queue_text(input logic [7:0] b);
        text_q.push_back('{CMD_TEXT, b});
        queued_words++;
    endtask

    task automatic queue_end(input logic [7:0] junk);
        text_q.push_back('{CMD_END, junk});
        queued_words++;
    endtask

    // Waits until every word is taken and every result has come out, then lets
    // the output stage settle before any register is touched.
    task automatic wait_idle();
        while (text_q.size() != 0 || feed_if.valid || rewritten_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SEARCH_PATTERN: cfg_pattern = val;
            CFG_SEARCH_LENGTH:
            begin
                cfg_slen = val[3:0];
                win_fill = 0;
            end
            CFG_REPLACE_TEXT:   cfg_rtext = val;
            CFG_REPLACE_LENGTH: cfg_rlen = val[3:0];
            default: ;
        endcase
    endtask

    // Mostly copies and prefixes of the pattern, with bytes from a small
    // alphabet and some fully random bytes mixed in.
    task automatic queue_random_string(input bit with_end);
        int slen;
        int segs;
        int kind;
        int n;
        int k;
        slen = search_span();
        segs = $urandom_range(0, 6);
        repeat (segs)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                for (k = 0; k < slen; k++)
                    queue_text(cfg_pattern[8*k +: 8]);
            end
            else if (kind < 60)
            begin
                n = $urandom_range(1, slen);
                for (k = 0; k < n; k++)
                    queue_text(cfg_pattern[8*k +: 8]);
            end
            else if (kind < 85)
            begin
                n = $urandom_range(1, 4);
                repeat (n) queue_text(alphabet[$urandom_range(0, 2)]);
            end
            else
            begin
                queue_text(8'($urandom_range(0, 255)));
            end
        end
        if (with_end)
            queue_end(8'($urandom_range(0, 255)));
    endtask

    initial
    begin : timeout
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int   r;
        int   k;
        int   strings;
        logic [63:0] pat;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        feed_if.valid       = 1'b0;
        feed_if.cmd         = CMD_TEXT;
        feed_if.text_byte   = 8'h00;
        result_if.ready     = 1'b0;
        cfg_pattern         = '0;
        cfg_slen            = 4'd1;
        cfg_rtext           = '0;
        cfg_rlen            = 4'd0;
        win_fill            = 0;
        tally               = '0;
        mismatches          = 0;
        queued_words        = 0;
        foreach (win[i])
            win[i] = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: every zero byte is a one-byte match and is deleted.
        queue_text(8'h00);
        queue_text(8'h41);
        queue_text(8'h00);
        queue_end(8'hFF);
        wait_idle();

        // Two-byte pattern with overlapping candidates; the trailing byte is
        // left in the window for the next length write to drop.
        write_reg(CFG_SEARCH_PATTERN, 64'h6261);
        write_reg(CFG_SEARCH_LENGTH, 64'd2);
        write_reg(CFG_REPLACE_TEXT, 64'h5A5958);
        write_reg(CFG_REPLACE_LENGTH, 64'd3);
        queue_text(8'h61);
        queue_text(8'h61);
        queue_text(8'h62);
        queue_text(8'h62);
        queue_text(8'h61);
        queue_text(8'h62);
        queue_text(8'h61);
        queue_end(8'h00);
        queue_text(8'h61);
        wait_idle();

        // Oversized lengths saturate to eight bytes.
        write_reg(CFG_SEARCH_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SEARCH_LENGTH, 64'd15);
        write_reg(CFG_REPLACE_TEXT, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_REPLACE_LENGTH, 64'd15);
        repeat (8) queue_text(8'hFF);
        queue_end(8'h5A);
        wait_idle();

        // A zero search length acts as one.
        write_reg(CFG_SEARCH_PATTERN, 64'h55);
        write_reg(CFG_SEARCH_LENGTH, 64'd0);
        write_reg(CFG_REPLACE_LENGTH, 64'd0);
        queue_text(8'h55);
        queue_text(8'hAA);
        queue_end(8'h00);
        wait_idle();

        while (queued_words < 180)
        begin
            for (k = 0; k < 3; k++)
                alphabet[k] = 8'($urandom_range(0, 255));
            pat = '0;
            for (k = 0; k < 8; k++)
                pat[8*k +: 8] = alphabet[$urandom_range(0, 2)];
            write_reg(CFG_SEARCH_PATTERN, pat);
            write_reg(CFG_REPLACE_TEXT, {$urandom, $urandom});
            r = $urandom_range(0, 9);
            write_reg(CFG_REPLACE_LENGTH,
                      64'((r == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8)));
            r = $urandom_range(0, 9);
            write_reg(CFG_SEARCH_LENGTH, 64'((r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15)
                                                           : $urandom_range(1, 8)));
            strings = $urandom_range(1, 3);
            for (k = 0; k < strings; k++)
                queue_random_string((k < strings - 1) || ($urandom_range(0, 9) != 0));
            wait_idle();
        end

        // A short run of single-byte deletions; the next string starts
        // counting from zero again.
        write_reg(CFG_SEARCH_PATTERN, 64'h3C);
        write_reg(CFG_SEARCH_LENGTH, 64'd1);
        write_reg(CFG_REPLACE_LENGTH, 64'd0);
        repeat (6) queue_text(8'h3C);
        queue_end(8'h00);
        queue_text(8'h3C);
        queue_text(8'h3C);
        queue_end(8'h00);
        wait_idle();

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/sfr_pkg.sv
sv/sfr_if.sv
sv/sfr_window.sv
sv/sfr_burst.sv
sv/stream_find_and_replace.sv
sv/sfr_checker.sv
test/stream_find_and_replace_tb.sv
